// ===== rtl/core/phase_min_consensus_node_unit_macros.svh =====
// assertion macros for the phase minimum consensus node
`ifndef PHASE_MIN_CONSENSUS_NODE_UNIT_MACROS_SVH
`define PHASE_MIN_CONSENSUS_NODE_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PMCN_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pmcn assertion failed");

// antecedent implies consequent in the next cycle
`define PMCN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pmcn assertion failed");

`endif

// ===== rtl/core/pmcn_pkg.sv =====
// types, constants and register codes shared by the consensus node modules
package pmcn_pkg;

	localparam int MAX_IN = 2;
	localparam int MAX_OUT = 2;
	localparam int NUM_ID = 2;

	localparam int VALUE_W = 32;
	localparam int SITE_W = 6;
	localparam int COUNT_W = 4;
	localparam int DIAM_W = 4;
	localparam int NUM_W = 2;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 40;

	localparam int PUSH_W = $clog2(MAX_OUT + 1);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DIAMETER    = 4'd0,
		REG_NUM_IN      = 4'd1,
		REG_NUM_OUT     = 4'd2,
		REG_START_VALUE = 4'd3,
		REG_IN_ID_0     = 4'd4,
		REG_IN_ID_1     = 4'd5,
		REG_OUT_ID_0    = 4'd6,
		REG_OUT_ID_1    = 4'd7
	} reg_idx_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_RECV  = 1'b1
	} op_t;

	typedef enum logic {
		KIND_SEND   = 1'b0,
		KIND_DECIDE = 1'b1
	} kind_t;

	typedef struct packed {
		logic [DIAM_W-1:0]                 diameter;
		logic [NUM_W-1:0]                  num_in;
		logic [NUM_W-1:0]                  num_out;
		logic signed [VALUE_W-1:0]         start_value;
		logic [NUM_ID-1:0][SITE_W-1:0]     in_id;
		logic [NUM_ID-1:0][SITE_W-1:0]     out_id;
	} cfg_t;

	typedef struct packed {
		op_t                       operation;
		logic [SITE_W-1:0]         source_site;
		logic signed [VALUE_W-1:0] message_value;
	} item_t;

	typedef struct packed {
		kind_t                     kind;
		logic [SITE_W-1:0]         dest_site;
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} result_t;

	typedef struct packed {
		logic [PUSH_W-1:0]               n;
		result_t [MAX_OUT-1:0]           res;
	} push_t;

endpackage

// ===== rtl/core/pmcn_cfg.sv =====
// configuration register file of the consensus node
module pmcn_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pmcn_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [pmcn_pkg::CFG_DATA_W-1:0]    cfg_data,
	output pmcn_pkg::cfg_t                     cfg
);
	import pmcn_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.diameter <= 4'd5;
			cfg_q.num_in <= 2'd1;
			cfg_q.num_out <= 2'd1;
			cfg_q.start_value <= '0;
			cfg_q.in_id <= '0;
			cfg_q.out_id <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DIAMETER:    cfg_q.diameter <= cfg_data[DIAM_W-1:0];
				REG_NUM_IN:      cfg_q.num_in <= cfg_data[NUM_W-1:0];
				REG_NUM_OUT:     cfg_q.num_out <= cfg_data[NUM_W-1:0];
				REG_START_VALUE: cfg_q.start_value <= cfg_data[VALUE_W-1:0];
				REG_IN_ID_0:     cfg_q.in_id[0] <= cfg_data[SITE_W-1:0];
				REG_IN_ID_1:     cfg_q.in_id[1] <= cfg_data[SITE_W-1:0];
				REG_OUT_ID_0:    cfg_q.out_id[0] <= cfg_data[SITE_W-1:0];
				REG_OUT_ID_1:    cfg_q.out_id[1] <= cfg_data[SITE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/pmcn_core.sv =====
// input register, node state and the per-word update and result logic
module pmcn_core (
	input  logic              clk,
	input  logic              arst_n,
	input  pmcn_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  pmcn_pkg::item_t   in_item,
	input  logic              room,
	output pmcn_pkg::push_t   push
);
	import pmcn_pkg::*;

	localparam logic [NUM_W-1:0] MAX_IN_N = NUM_W'(MAX_IN);
	localparam logic [NUM_W-1:0] MAX_OUT_N = NUM_W'(MAX_OUT);

	logic                      valid_s1;
	item_t                     item_s1;
	logic                      fire;

	logic signed [VALUE_W-1:0]            min_q, min_n;
	logic [MAX_IN-1:0][COUNT_W-1:0]       counts_q, counts_n;
	logic [COUNT_W-1:0]                   send_q, send_n;
	logic                                 decided_q, decided_n;

	logic [NUM_W-1:0] n_in;
	logic [NUM_W-1:0] n_out;
	logic             skip;
	logic             found;
	logic             all_done;
	logic             can_send;

	assign fire = valid_s1 && room;
	assign in_ready = !valid_s1 || room;
	assign n_in = (cfg.num_in > MAX_IN_N) ? MAX_IN_N : cfg.num_in;
	assign n_out = (cfg.num_out > MAX_OUT_N) ? MAX_OUT_N : cfg.num_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_comb begin
		min_n = min_q;
		counts_n = counts_q;
		send_n = send_q;
		decided_n = decided_q;
		skip = 1'b0;
		found = 1'b0;
		all_done = 1'b1;
		can_send = 1'b1;
		push = '0;

		if (item_s1.operation == OP_START) begin
			counts_n = '0;
			send_n = '0;
			min_n = cfg.start_value;
			decided_n = 1'b0;
		end else if (decided_q) begin
			skip = 1'b1;
		end else begin
			for (int i = 0; i < MAX_IN; i++) begin
				if (!found && (NUM_W'(i) < n_in) &&
						(cfg.in_id[i] == item_s1.source_site)) begin
					found = 1'b1;
					if ($signed(item_s1.message_value) < $signed(min_q)) begin
						min_n = item_s1.message_value;
					end
					if (counts_q[i] != COUNT_MAX) begin
						counts_n[i] = counts_q[i] + 1'b1;
					end
				end
			end
		end

		for (int i = 0; i < MAX_IN; i++) begin
			if (NUM_W'(i) < n_in) begin
				if (counts_n[i] < cfg.diameter) begin
					all_done = 1'b0;
				end
				if (!((counts_n[i] >= send_n) && (send_n < cfg.diameter))) begin
					can_send = 1'b0;
				end
			end
		end

		if (!skip) begin
			if (all_done) begin
				decided_n = 1'b1;
				push.n = PUSH_W'(1);
				push.res[0].kind = KIND_DECIDE;
				push.res[0].dest_site = '0;
				push.res[0].value = min_n;
				push.res[0].last = 1'b1;
			end else if (can_send) begin
				push.n = PUSH_W'(n_out);
				for (int i = 0; i < MAX_OUT; i++) begin
					push.res[i].kind = KIND_SEND;
					push.res[i].dest_site = cfg.out_id[i];
					push.res[i].value = min_n;
					push.res[i].last = (NUM_W'(i + 1) == n_out);
				end
				if (send_n != COUNT_MAX) begin
					send_n = send_n + 1'b1;
				end
			end
		end

		if (!fire) begin
			push.n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			counts_q <= '0;
			send_q <= '0;
			decided_q <= 1'b0;
		end else if (fire) begin
			min_q <= min_n;
			counts_q <= counts_n;
			send_q <= send_n;
			decided_q <= decided_n;
		end
	end

endmodule

// ===== rtl/core/pmcn_fifo.sv =====
// result queue, takes up to two words a cycle and hands out one while out_ready is high
module pmcn_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  pmcn_pkg::push_t    push,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output pmcn_pkg::result_t  out_res
);
	import pmcn_pkg::*;

	localparam logic [FIFO_CNT_W-1:0] ROOM_LIMIT = FIFO_CNT_W'(FIFO_DEPTH - MAX_OUT);

	result_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [FIFO_CNT_W-1:0]  count_q;
	logic                   pop;

	assign out_valid = (count_q != '0);
	assign pop = out_valid && out_ready;
	assign room = (count_q <= ROOM_LIMIT);
	assign out_res = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_OUT; k++) begin
			if (PUSH_W'(k) < push.n) begin
				mem_q[wr_ptr_q + FIFO_PTR_W'(k)] <= push.res[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(push.n);
			rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(pop);
			count_q <= count_q + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
		end
	end

endmodule

// ===== rtl/core/phase_min_consensus_node_unit.sv =====
// an accepted word waits in the input register until the result queue has room
// throughput: one input word per cycle while the result queue has room for two words
// the output port moves one result word per cycle while m_tready is high; an input word
// causes one or two result words, or none
// reset: arst_n clears the node state, the queue and the registers to their defaults
module phase_min_consensus_node_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// source_site [5:0], message_value [37:6], zero [39:38]
	input  logic [pmcn_pkg::IN_DATA_W-1:0]      s_tdata,
	// operation [0]
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// dest_site [5:0], value [37:6], zero [39:38]
	output logic [pmcn_pkg::OUT_DATA_W-1:0]     m_tdata,
	// kind [0]
	output logic                                m_tuser,
	output logic                                m_tlast,
	input  logic                                cfg_we,
	input  logic [pmcn_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [pmcn_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pmcn_pkg::*;
	`include "phase_min_consensus_node_unit_macros.svh"

	cfg_t     cfg;
	item_t    in_item;
	push_t    push;
	logic     room;
	result_t  out_res;

	assign in_item.operation = op_t'(s_tuser);
	assign in_item.source_site = s_tdata[SITE_W-1:0];
	assign in_item.message_value = s_tdata[SITE_W+VALUE_W-1:SITE_W];

	pmcn_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pmcn_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.room     (room),
		.push     (push)
	);

	pmcn_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {{(OUT_DATA_W - SITE_W - VALUE_W){1'b0}}, out_res.value, out_res.dest_site};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last;

	`PMCN_ASSERT_SAME(a_push_has_room, clk, arst_n, push.n != '0, room)
	`PMCN_ASSERT_SAME(a_push_bounded, clk, arst_n, 1'b1, push.n <= PUSH_W'(MAX_OUT))
	`PMCN_ASSERT_SAME(a_decide_single, clk, arst_n, m_tvalid && (m_tuser == KIND_DECIDE), m_tlast && (m_tdata[SITE_W-1:0] == '0))

endmodule
